// ===== src/rlss_pkg.sv =====
// Shared constants, codes and types of the single-wire RGB LED strip serialiser.
// No dependencies; rlss_cfg, rlss_seq, rlss_pix and the top level import this package.
`timescale 1ns / 1ps

package rlss_pkg;

	localparam int LED_COUNT    = 64;
	localparam int BITS_PER_LED = 24;
	localparam int PIX_W        = 24;
	localparam int LED_AW       = (LED_COUNT > 1) ? $clog2(LED_COUNT) : 1;
	localparam int BIT_W        = $clog2(BITS_PER_LED);
	localparam int PIX_IW       = $clog2(PIX_W);
	localparam int IDX_W        = 6;
	localparam int LVL_W        = 8;
	localparam int TICK_W       = 16;
	localparam int PER_W        = 8;
	localparam int CFG_AW       = 2;
	localparam int CFG_DW       = 16;

	localparam logic [PER_W-1:0]  RST_BIT_PERIOD = PER_W'(52);
	localparam logic [PER_W-1:0]  RST_ZERO_HIGH  = PER_W'(10);
	localparam logic [PER_W-1:0]  RST_ONE_HIGH   = PER_W'(27);
	localparam logic [TICK_W-1:0] RST_GUARD      = TICK_W'(2310);

	typedef enum logic [CFG_AW-1:0] {
		CFG_BIT_PERIOD = 2'd0,
		CFG_ZERO_HIGH  = 2'd1,
		CFG_ONE_HIGH   = 2'd2,
		CFG_GUARD      = 2'd3
	} cfg_idx_t;

	typedef enum logic [1:0] {
		ACT_WRITE = 2'd0,
		ACT_START = 2'd1,
		ACT_TICK  = 2'd2
	} action_t;

	typedef enum logic [1:0] {
		PH_IDLE  = 2'd0,
		PH_LEAD  = 2'd1,
		PH_DATA  = 2'd2,
		PH_GUARD = 2'd3
	} phase_t;

	typedef struct packed {
		logic [PER_W-1:0]  bit_period;
		logic [PER_W-1:0]  zero_high;
		logic [PER_W-1:0]  one_high;
		logic [TICK_W-1:0] guard;
	} cfg_t;

	// Sequencer view of one word after its start request, before its tick.
	typedef struct packed {
		phase_t             phase;
		logic [LED_AW-1:0]  led;
		logic [BIT_W-1:0]   bitpos;
		logic [TICK_W-1:0]  tick;
		logic               ignored;
	} seq_snap_t;

endpackage

// ===== src/rlss_ram.sv =====
// Generic single-port-write, single-port-read RAM with a registered read.
// No dependencies.
`timescale 1ns / 1ps

module rlss_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                             clk,
	input  logic                             we,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
	input  logic [WIDTH-1:0]                 wdata,
	input  logic                             re,
	input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
	output logic [WIDTH-1:0]                 rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// A read at the address being written returns the old contents.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ===== src/rlss_cfg.sv =====
// Configuration register file of the LED strip serialiser.
// Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_cfg
	import rlss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr,
	input  logic [CFG_AW-1:0] index,
	input  logic [CFG_DW-1:0] data,
	output cfg_t              cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.bit_period <= RST_BIT_PERIOD;
			cfg_q.zero_high  <= RST_ZERO_HIGH;
			cfg_q.one_high   <= RST_ONE_HIGH;
			cfg_q.guard      <= RST_GUARD;
		end else if (wr) begin
			case (cfg_idx_t'(index))
				CFG_BIT_PERIOD: cfg_q.bit_period <= data[PER_W-1:0];
				CFG_ZERO_HIGH:  cfg_q.zero_high  <= data[PER_W-1:0];
				CFG_ONE_HIGH:   cfg_q.one_high   <= data[PER_W-1:0];
				CFG_GUARD:      cfg_q.guard      <= data[TICK_W-1:0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

// ===== src/rlss_seq.sv =====
// Frame sequencer: phase, LED position, bit position and tick counter.
// Depends on rlss_pkg.
`timescale 1ns / 1ps

module rlss_seq
	import rlss_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        acc,
	input  logic [1:0]  action,
	input  cfg_t        cfg,
	output seq_snap_t   snap
);

	phase_t             phase_q, phase_d;
	logic [LED_AW-1:0]  led_q, led_d;
	logic [BIT_W-1:0]   bit_q, bit_d;
	logic [TICK_W-1:0]  tick_q, tick_d;
	seq_snap_t          a;
	logic [PER_W-1:0]   period;
	logic [TICK_W-1:0]  guard;
	logic [TICK_W:0]    tick_inc;
	logic               period_end;
	logic               guard_end;
	logic               last_bit;
	logic               last_led;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_IDLE;
			led_q   <= '0;
			bit_q   <= '0;
			tick_q  <= '0;
		end else begin
			phase_q <= phase_d;
			led_q   <= led_d;
			bit_q   <= bit_d;
			tick_q  <= tick_d;
		end
	end

	always_comb begin
		// Start request first; it is refused while a frame is running.
		a.phase   = phase_q;
		a.led     = led_q;
		a.bitpos  = bit_q;
		a.tick    = tick_q;
		a.ignored = 1'b0;
		if (acc && action == ACT_START) begin
			if (phase_q != PH_IDLE) begin
				a.ignored = 1'b1;
			end else begin
				a.phase  = PH_LEAD;
				a.led    = '0;
				a.bitpos = '0;
				a.tick   = '0;
			end
		end

		period     = (cfg.bit_period == '0) ? PER_W'(1) : cfg.bit_period;
		guard      = (cfg.guard == '0) ? TICK_W'(1) : cfg.guard;
		tick_inc   = {1'b0, a.tick} + (TICK_W+1)'(1);
		period_end = tick_inc >= (TICK_W+1)'(period);
		guard_end  = tick_inc >= {1'b0, guard};
		last_bit   = ({1'b0, a.bitpos} + (BIT_W+1)'(1)) >= (BIT_W+1)'(BITS_PER_LED);
		last_led   = ({1'b0, a.led} + (LED_AW+1)'(1)) >= (LED_AW+1)'(LED_COUNT);

		phase_d = a.phase;
		led_d   = a.led;
		bit_d   = a.bitpos;
		tick_d  = a.tick;
		if (acc && action == ACT_TICK) begin
			case (a.phase)
				PH_LEAD: begin
					if (period_end) begin
						tick_d  = '0;
						phase_d = PH_DATA;
						led_d   = '0;
						bit_d   = '0;
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				PH_DATA: begin
					if (period_end) begin
						tick_d = '0;
						if (last_bit) begin
							bit_d = '0;
							if (last_led) begin
								led_d   = '0;
								phase_d = PH_GUARD;
							end else begin
								led_d = a.led + LED_AW'(1);
							end
						end else begin
							bit_d = a.bitpos + BIT_W'(1);
						end
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				PH_GUARD: begin
					if (guard_end) begin
						tick_d  = '0;
						phase_d = PH_IDLE;
					end else begin
						tick_d = tick_inc[TICK_W-1:0];
					end
				end
				default: ;
			endcase
		end
	end

	assign snap = a;

endmodule

// ===== src/rlss_pix.sv =====
// Pixel store: RAM of green-red-blue words with valid bits and write forwarding.
// Depends on rlss_pkg and rlss_ram.
`timescale 1ns / 1ps

module rlss_pix
	import rlss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,
	input  logic              s1_en,
	input  logic              we,
	input  logic [LED_AW-1:0] waddr,
	input  logic [PIX_W-1:0]  wdata,
	input  logic [LED_AW-1:0] raddr,
	output logic [PIX_W-1:0]  word_s1
);

	logic [LED_COUNT-1:0] vld_q;
	logic [PIX_W-1:0]     ram_rdata;
	logic                 vld_s1;
	logic                 fwd_s1;
	logic [PIX_W-1:0]     fwd_data_s1;

	rlss_ram #(
		.WIDTH (PIX_W),
		.DEPTH (LED_COUNT)
	) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (waddr),
		.wdata (wdata),
		.re    (s1_en),
		.raddr (raddr),
		.rdata (ram_rdata)
	);

	// An entry never written reads as zero.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (we) begin
			vld_q[waddr] <= 1'b1;
		end
	end

	// The RAM returns old data when the same word writes the entry it reads,
	// so that write is carried alongside and takes precedence.
	always_ff @(posedge clk) begin
		if (s1_en) begin
			vld_s1      <= vld_q[raddr];
			fwd_s1      <= we && (waddr == raddr);
			fwd_data_s1 <= wdata;
		end
	end

	assign word_s1 = fwd_s1 ? fwd_data_s1 : (vld_s1 ? ram_rdata : '0);

endmodule

// ===== src/rgb_led_strip_serializer_core.sv =====
// Top level of the single-wire RGB LED strip serialiser.
// Depends on rlss_pkg, rlss_cfg, rlss_seq, rlss_pix and rlss_ram.
//
//   Channel   Handshake                 Payload
//   input     in_valid / in_stall       action, led_index, red_level, green_level, blue_level
//   output    out_valid / out_stall     line_level, frame_busy, start_ignored
//   config    cfg_valid / cfg_ready     cfg_index, cfg_data
//
// One input word is taken every clock cycle unless the input is stalled; its result passes
// through the registered read of the pixel RAM and then the output register.
// Reset clears the frame sequencer, the pixel valid bits, the pipeline valids and
// loads the register defaults; no clearing pass is needed.
// A stall on the output holds the output register and the RAM read stage; the input
// is stalled only once both are full.
`timescale 1ns / 1ps

module rgb_led_strip_serializer_core
	import rlss_pkg::*;
(
	input  logic              clk,
	input  logic              arst_n,

	input  logic              in_valid,
	output logic              in_stall,
	input  logic [1:0]        action,
	input  logic [IDX_W-1:0]  led_index,
	input  logic [LVL_W-1:0]  red_level,
	input  logic [LVL_W-1:0]  green_level,
	input  logic [LVL_W-1:0]  blue_level,

	output logic              out_valid,
	input  logic              out_stall,
	output logic              line_level,
	output logic              frame_busy,
	output logic              start_ignored,

	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [CFG_AW-1:0] cfg_index,
	input  logic [CFG_DW-1:0] cfg_data
);

	cfg_t              cfg;
	seq_snap_t         snap;
	seq_snap_t         snap_s1;
	logic              s1_v;
	logic              out_v_q;
	logic              line_q;
	logic              busy_q;
	logic              ign_q;
	logic              out_en;
	logic              s1_en;
	logic              in_acc;
	logic              pix_we;
	logic [PIX_W-1:0]  word_s1;
	logic              bit_s1;
	logic [PIX_IW-1:0] sel_s1;
	logic [PER_W-1:0]  high_s1;
	logic              line_s1;

	// The output register loads when empty or being taken; the RAM read stage
	// moves on when it is empty or the output register can take its word.
	assign out_en   = !out_v_q || !out_stall;
	assign s1_en    = !s1_v || out_en;
	assign in_stall = !s1_en;
	assign in_acc   = in_valid && s1_en;

	assign cfg_ready = 1'b1;

	rlss_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.wr     (cfg_valid && cfg_ready),
		.index  (cfg_index),
		.data   (cfg_data),
		.cfg    (cfg)
	);

	rlss_seq u_seq (
		.clk    (clk),
		.arst_n (arst_n),
		.acc    (in_acc),
		.action (action),
		.cfg    (cfg),
		.snap   (snap)
	);

	// Writes beyond the strip length are dropped.
	assign pix_we = in_acc && (action == ACT_WRITE) &&
			((IDX_W+LED_AW)'(led_index) < (IDX_W+LED_AW)'(LED_COUNT));

	rlss_pix u_pix (
		.clk     (clk),
		.arst_n  (arst_n),
		.s1_en   (s1_en),
		.we      (pix_we),
		.waddr   (LED_AW'(led_index)),
		.wdata   ({green_level, red_level, blue_level}),
		.raddr   (snap.led),
		.word_s1 (word_s1)
	);

	// Stage 1 holds the sequencer view of the word while the pixel is read.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_v <= 1'b0;
		end else if (s1_en) begin
			s1_v <= in_acc;
		end
	end

	always_ff @(posedge clk) begin
		if (s1_en) begin
			snap_s1 <= snap;
		end
	end

	// The bit being sent is taken most significant first; bits past the stored
	// word are sent as zeros. The line is high for the first part of the period.
	always_comb begin
		sel_s1 = PIX_IW'(PIX_W - 1) - snap_s1.bitpos[PIX_IW-1:0];
		if ((BIT_W+1)'(snap_s1.bitpos) < (BIT_W+1)'(PIX_W)) begin
			bit_s1 = word_s1[sel_s1];
		end else begin
			bit_s1 = 1'b0;
		end
		high_s1 = bit_s1 ? cfg.one_high : cfg.zero_high;
		line_s1 = (snap_s1.phase == PH_DATA) && (snap_s1.tick < TICK_W'(high_s1));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_v_q <= 1'b0;
		end else if (out_en) begin
			out_v_q <= s1_v;
		end
	end

	always_ff @(posedge clk) begin
		if (out_en) begin
			line_q <= line_s1;
			busy_q <= snap_s1.phase != PH_IDLE;
			ign_q  <= snap_s1.ignored;
		end
	end

	assign out_valid     = out_v_q;
	assign line_level    = line_q;
	assign frame_busy    = busy_q;
	assign start_ignored = ign_q;

	a_line_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && line_level |-> frame_busy)
		else $error("line driven high outside a frame");

	a_ignore_needs_busy: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && start_ignored |-> frame_busy)
		else $error("start refused while idle");

	a_idle_counters_clear: assert property (@(posedge clk) disable iff (!arst_n)
		(snap.phase == PH_IDLE) |->
		(snap.tick == '0 && snap.led == '0 && snap.bitpos == '0))
		else $error("sequencer counters not cleared while idle");

	a_s1_held_on_stall: assert property (@(posedge clk) disable iff (!arst_n)
		s1_v && out_v_q && out_stall |=> s1_v && $stable(snap_s1))
		else $error("read stage lost its word under stall");

endmodule
